/* rtl/ppes_pkg.sv */
// ----------------------------------------------------------------------------
// ppes_pkg
// Shared types, constants and arithmetic helpers of the particle pool block.
// ----------------------------------------------------------------------------
package ppes_pkg;

	localparam int POOL_SIZE_DEF = 64;
	localparam int MAX_RES       = 64;
	localparam int CORDIC_STEPS  = 16;

	localparam logic OP_SPAWN = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	localparam logic signed [20:0] GAIN_Q20 = 21'sd636752;
	localparam logic signed [27:0] DEG_90   = 28'sd5898240;
	localparam logic signed [27:0] DEG_180  = 28'sd11796480;
	localparam logic signed [27:0] DEG_360  = 28'sd23592960;

	typedef struct packed {
		logic               opcode;
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [15:0] angle_deg;
		logic [30:0]        start_speed;
		logic [30:0]        life_span;
		logic [30:0]        dot_radius;
		logic [31:0]        rgba_color;
		logic [23:0]        time_step;
	} cmd_t;

	typedef struct packed {
		logic               valid_res;
		logic [5:0]         slot_index;
		logic signed [31:0] now_x;
		logic signed [31:0] now_y;
		logic [30:0]        out_radius;
		logic [31:0]        out_color;
		logic               still_alive;
		logic               last;
	} res_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] life;
		logic [30:0]        radius;
		logic [31:0]        color;
	} ent_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// round a Q.32 product to Q16.16, ties toward plus infinity
	function automatic logic signed [40:0] mul_round(input logic signed [56:0] p);
		logic signed [56:0] t;
		t = p + 57'sd32768;
		return t[56:16];
	endfunction

	function automatic logic signed [27:0] atan_deg(input logic [3:0] i);
		case (i)
			4'd0:    return 28'sd2949120;
			4'd1:    return 28'sd1740967;
			4'd2:    return 28'sd919879;
			4'd3:    return 28'sd466945;
			4'd4:    return 28'sd234379;
			4'd5:    return 28'sd117304;
			4'd6:    return 28'sd58666;
			4'd7:    return 28'sd29335;
			4'd8:    return 28'sd14668;
			4'd9:    return 28'sd7334;
			4'd10:   return 28'sd3667;
			4'd11:   return 28'sd1833;
			4'd12:   return 28'sd917;
			4'd13:   return 28'sd458;
			4'd14:   return 28'sd229;
			4'd15:   return 28'sd115;
			default: return 28'sd0;
		endcase
	endfunction

endpackage

/* rtl/ppes_front.sv */
// ----------------------------------------------------------------------------
// ppes_front
// Input handshake and a two-entry command queue toward the execution side.
// ----------------------------------------------------------------------------
module ppes_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [15:0] angle_deg,
	input  logic [30:0]        start_speed,
	input  logic [30:0]        life_span,
	input  logic [30:0]        dot_radius,
	input  logic [31:0]        rgba_color,
	input  logic [23:0]        time_step,
	output ppes_pkg::cmd_t     cmd,
	output logic               cmd_valid,
	input  logic               cmd_ready
);
	import ppes_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;
	cmd_t       in_cmd;

	always_comb begin
		in_cmd.opcode      = (opcode == OP_TICK) ? OP_TICK : OP_SPAWN;
		in_cmd.start_x     = start_x;
		in_cmd.start_y     = start_y;
		in_cmd.angle_deg   = angle_deg;
		in_cmd.start_speed = start_speed;
		in_cmd.life_span   = life_span;
		in_cmd.dot_radius  = dot_radius;
		in_cmd.rgba_color  = rgba_color;
		in_cmd.time_step   = time_step;
	end

	assign in_ready  = (count_q != 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = entry_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

/* rtl/ppes_cordic.sv */
// ----------------------------------------------------------------------------
// ppes_cordic
// Iterative CORDIC rotation: angle and speed to a velocity vector, one step
// per cycle, then gain scaling and saturation.
// ----------------------------------------------------------------------------
module ppes_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] angle,
	input  logic [30:0]        speed,
	output logic               done,
	output logic signed [31:0] vx,
	output logic signed [31:0] vy
);
	import ppes_pkg::*;

	typedef enum logic [1:0] {C_IDLE, C_ITER, C_MUL, C_OUT} cstate_t;

	cstate_t            state_q;
	logic [3:0]         step_q;
	logic signed [41:0] x_q;
	logic signed [41:0] y_q;
	logic signed [27:0] z_q;
	logic               neg_q;
	logic signed [62:0] px_q;
	logic signed [62:0] py_q;
	logic               done_q;
	logic signed [31:0] vx_q;
	logic signed [31:0] vy_q;

	logic signed [27:0] z0;
	logic signed [27:0] z1;
	logic signed [27:0] z2;
	logic               neg0;
	logic signed [41:0] xs;
	logic signed [41:0] ys;
	logic signed [41:0] xn;
	logic signed [41:0] yn;
	logic signed [27:0] zn;
	logic signed [63:0] rx;
	logic signed [63:0] ry;

	// fold the angle into plus or minus 90 degrees
	always_comb begin
		z0 = {{3{angle[15]}}, angle, 9'b0};
		if (z0 >= DEG_180) begin
			z1 = z0 - DEG_360;
		end else if (z0 < -DEG_180) begin
			z1 = z0 + DEG_360;
		end else begin
			z1 = z0;
		end
		neg0 = 1'b0;
		z2   = z1;
		if (z1 > DEG_90) begin
			z2   = z1 - DEG_180;
			neg0 = 1'b1;
		end else if (z1 < -DEG_90) begin
			z2   = z1 + DEG_180;
			neg0 = 1'b1;
		end
	end

	always_comb begin
		xs = x_q >>> step_q;
		ys = y_q >>> step_q;
		if (z_q >= 28'sd0) begin
			xn = x_q - ys;
			yn = y_q + xs;
			zn = z_q - atan_deg(step_q);
		end else begin
			xn = x_q + ys;
			yn = y_q - xs;
			zn = z_q + atan_deg(step_q);
		end
		rx = (64'(px_q) + 64'sd134217728) >>> 28;
		ry = (64'(py_q) + 64'sd134217728) >>> 28;
	end

	assign done = done_q;
	assign vx   = vx_q;
	assign vy   = vy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			step_q  <= 4'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (start) begin
						x_q     <= 42'({speed, 8'b0});
						y_q     <= 42'sd0;
						z_q     <= z2;
						neg_q   <= neg0;
						step_q  <= 4'd0;
						state_q <= C_ITER;
					end
				end
				C_ITER: begin
					x_q    <= xn;
					y_q    <= yn;
					z_q    <= zn;
					step_q <= step_q + 4'd1;
					if (step_q == 4'(CORDIC_STEPS - 1)) begin
						state_q <= C_MUL;
					end
				end
				C_MUL: begin
					px_q    <= (neg_q ? -x_q : x_q) * GAIN_Q20;
					py_q    <= (neg_q ? -y_q : y_q) * GAIN_Q20;
					state_q <= C_OUT;
				end
				C_OUT: begin
					vx_q    <= sat32(rx);
					vy_q    <= sat32(ry);
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

endmodule

/* rtl/ppes_back.sv */
// ----------------------------------------------------------------------------
// ppes_back
// Execution side: spawns into the slot memory and walks the pool on a tick,
// with a held-back result so the final one can carry the last mark.
// ----------------------------------------------------------------------------
module ppes_back #(
	parameter int POOL_SIZE = ppes_pkg::POOL_SIZE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ppes_pkg::cmd_t     cmd,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  logic signed [31:0] gravity,
	output ppes_pkg::res_t     res,
	output logic               res_valid,
	input  logic               res_ready
);
	import ppes_pkg::*;

	localparam int IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(POOL_SIZE - 1);

	typedef enum logic [2:0] {S_IDLE, S_CORD, S_SPWR, S_SCAN, S_MUL, S_UPD, S_FIN} state_t;

	state_t                 state_q;
	cmd_t                   cmd_q;
	logic [IW-1:0]          idx_q;
	logic [IW-1:0]          wp_q;
	logic [POOL_SIZE-1:0]   alive_q;
	logic [6:0]             n_q;
	res_t                   pend_q;
	logic                   pend_v_q;
	res_t                   res_q;
	logic                   res_v_q;
	ent_t                   mem_q [POOL_SIZE];
	ent_t                   rd_q;
	logic signed [56:0]     mx_q;
	logic signed [56:0]     my_q;
	logic signed [56:0]     mg_q;

	logic                   cord_start;
	logic                   cord_done;
	logic signed [31:0]     cord_vx;
	logic signed [31:0]     cord_vy;
	logic                   out_free;
	logic                   record;
	logic                   upd_go;
	logic                   wr_en;
	logic [IW-1:0]          wr_addr;
	ent_t                   wr_data;
	ent_t                   upd_ent;
	res_t                   upd_res;
	res_t                   spawn_res;
	res_t                   fin_res;
	logic                   alive_new;
	logic signed [24:0]     dt_s;

	ppes_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.angle  (cmd.angle_deg),
		.speed  (cmd.start_speed),
		.done   (cord_done),
		.vx     (cord_vx),
		.vy     (cord_vy)
	);

	assign cmd_ready  = (state_q == S_IDLE);
	assign cord_start = (state_q == S_IDLE) && cmd_valid && (cmd.opcode == OP_SPAWN);
	assign out_free   = !res_v_q || res_ready;
	assign record     = (n_q < 7'(MAX_RES));
	assign upd_go     = !(record && pend_v_q) || out_free;
	assign dt_s       = $signed({1'b0, cmd_q.time_step});
	assign res        = res_q;
	assign res_valid  = res_v_q;

	always_comb begin
		upd_ent       = rd_q;
		upd_ent.pos_x = sat32(64'($signed(rd_q.pos_x)) + 64'(mul_round(mx_q)));
		upd_ent.pos_y = sat32(64'($signed(rd_q.pos_y)) + 64'(mul_round(my_q)));
		upd_ent.vel_y = sat32(64'($signed(rd_q.vel_y)) + 64'(mul_round(mg_q)));
		upd_ent.life  = sat32(64'($signed(rd_q.life)) - 64'(dt_s));
		alive_new     = (upd_ent.life > 32'sd0);

		upd_res.valid_res   = 1'b1;
		upd_res.slot_index  = 6'(idx_q);
		upd_res.now_x       = upd_ent.pos_x;
		upd_res.now_y       = upd_ent.pos_y;
		upd_res.out_radius  = rd_q.radius;
		upd_res.out_color   = rd_q.color;
		upd_res.still_alive = alive_new;
		upd_res.last        = 1'b0;

		spawn_res.valid_res   = 1'b1;
		spawn_res.slot_index  = 6'(wp_q);
		spawn_res.now_x       = cmd_q.start_x;
		spawn_res.now_y       = cmd_q.start_y;
		spawn_res.out_radius  = cmd_q.dot_radius;
		spawn_res.out_color   = cmd_q.rgba_color;
		spawn_res.still_alive = 1'b1;
		spawn_res.last        = 1'b1;

		// final item of a tick: the held result, or an empty one
		fin_res      = pend_v_q ? pend_q : '0;
		fin_res.last = 1'b1;

		if (state_q == S_SPWR) begin
			wr_en   = out_free;
			wr_addr = wp_q;
		end else begin
			wr_en   = (state_q == S_UPD) && upd_go;
			wr_addr = idx_q;
		end
		if (state_q == S_SPWR) begin
			wr_data.pos_x  = cmd_q.start_x;
			wr_data.pos_y  = cmd_q.start_y;
			wr_data.vel_x  = cord_vx;
			wr_data.vel_y  = cord_vy;
			wr_data.life   = $signed({1'b0, cmd_q.life_span});
			wr_data.radius = cmd_q.dot_radius;
			wr_data.color  = cmd_q.rgba_color;
		end else begin
			wr_data = upd_ent;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[idx_q];
		if (state_q == S_MUL) begin
			mx_q <= $signed(rd_q.vel_x) * dt_s;
			my_q <= $signed(rd_q.vel_y) * dt_s;
			mg_q <= gravity * dt_s;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			idx_q    <= '0;
			wp_q     <= '0;
			alive_q  <= '0;
			n_q      <= 7'd0;
			pend_v_q <= 1'b0;
			res_v_q  <= 1'b0;
		end else begin
			if (res_v_q && res_ready) begin
				res_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q    <= cmd;
						idx_q    <= '0;
						n_q      <= 7'd0;
						pend_v_q <= 1'b0;
						state_q  <= (cmd.opcode == OP_SPAWN) ? S_CORD : S_SCAN;
					end
				end
				S_CORD: begin
					if (cord_done) begin
						state_q <= S_SPWR;
					end
				end
				S_SPWR: begin
					if (out_free) begin
						alive_q[wp_q] <= 1'b1;
						res_q         <= spawn_res;
						res_v_q       <= 1'b1;
						wp_q          <= (wp_q == LAST_IDX) ? '0 : wp_q + 1'b1;
						state_q       <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (alive_q[idx_q]) begin
						state_q <= S_MUL;
					end else if (idx_q == LAST_IDX) begin
						state_q <= S_FIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_MUL: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (upd_go) begin
						alive_q[idx_q] <= alive_new;
						if (record) begin
							// push the held result out, hold the new one
							if (pend_v_q) begin
								res_q   <= pend_q;
								res_v_q <= 1'b1;
							end
							pend_q   <= upd_res;
							pend_v_q <= 1'b1;
							n_q      <= n_q + 7'd1;
						end
						if (idx_q == LAST_IDX) begin
							state_q <= S_FIN;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_SCAN;
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						res_q    <= fin_res;
						res_v_q  <= 1'b1;
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/particle_pool_euler_step_top.sv */
// ----------------------------------------------------------------------------
// particle_pool_euler_step_top
// Ring-written particle pool with fixed-point Euler update.
//
//   channel   signals                         direction
//   input     in_valid / in_ready + fields    in
//   result    out_valid / out_ready + fields  out
//   config    cfg_we / cfg_wdata              in (gravity_accel)
//
// A spawn's duration is set by the 16-step CORDIC plus scaling.
// A tick's duration is set by the slot walk: each slot is checked in turn,
// and each live slot adds a multiply stage and a write-back.
// Reset clears the live flags, write pointer and gravity; no clearing pass.
// A stalled result output holds the walk; the two-entry queue keeps
// taking items meanwhile until it is full.
// ----------------------------------------------------------------------------
module particle_pool_euler_step_top #(
	parameter int POOL_SIZE = ppes_pkg::POOL_SIZE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [15:0] angle_deg,
	input  logic [30:0]        start_speed,
	input  logic [30:0]        life_span,
	input  logic [30:0]        dot_radius,
	input  logic [31:0]        rgba_color,
	input  logic [23:0]        time_step,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               valid_res,
	output logic [5:0]         slot_index,
	output logic signed [31:0] now_x,
	output logic signed [31:0] now_y,
	output logic [30:0]        out_radius,
	output logic [31:0]        out_color,
	output logic               still_alive,
	output logic               last
);
	import ppes_pkg::*;

	logic signed [31:0] gravity_q;
	cmd_t               cmd;
	logic               cmd_valid;
	logic               cmd_ready;
	res_t               res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q <= 32'sd0;
		end else if (cfg_we) begin
			gravity_q <= $signed(cfg_wdata);
		end
	end

	ppes_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.start_x     (start_x),
		.start_y     (start_y),
		.angle_deg   (angle_deg),
		.start_speed (start_speed),
		.life_span   (life_span),
		.dot_radius  (dot_radius),
		.rgba_color  (rgba_color),
		.time_step   (time_step),
		.cmd         (cmd),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready)
	);

	ppes_back #(
		.POOL_SIZE (POOL_SIZE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.gravity   (gravity_q),
		.res       (res),
		.res_valid (out_valid),
		.res_ready (out_ready)
	);

	assign valid_res   = res.valid_res;
	assign slot_index  = res.slot_index;
	assign now_x       = res.now_x;
	assign now_y       = res.now_y;
	assign out_radius  = res.out_radius;
	assign out_color   = res.out_color;
	assign still_alive = res.still_alive;
	assign last        = res.last;

endmodule

/* dv/tb_particle_pool_euler_step_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_particle_pool_euler_step_top
// Self-checking bench for the particle pool Euler step block. Spawn and tick
// items go in over a valid/ready channel; a local pool model computes the
// slot results, which are compared field by field as they come out, under
// random stalls on both sides and several gravity settings.
// ----------------------------------------------------------------------------
module tb_particle_pool_euler_step_top;
	import ppes_pkg::*;

	localparam int  POOL      = 64;
	localparam int  CYC_LIMIT = 1000000;
	localparam int  DRAIN     = 300;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [31:0]        cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic               opcode;
	logic signed [31:0] start_x, start_y;
	logic signed [15:0] angle_deg;
	logic [30:0]        start_speed, life_span, dot_radius;
	logic [31:0]        rgba_color;
	logic [23:0]        time_step;
	logic               out_valid;
	logic               out_ready;
	logic               valid_res;
	logic [5:0]         slot_index;
	logic signed [31:0] now_x, now_y;
	logic [30:0]        out_radius;
	logic [31:0]        out_color;
	logic               still_alive;
	logic               last;

	particle_pool_euler_step_top dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// particle pool shadow
	int          px [POOL], py [POOL], vx [POOL], vy [POOL], life [POOL];
	logic [30:0] radius [POOL];
	logic [31:0] color [POOL];
	bit          alive [POOL];
	int          wr_ptr;
	int          gravity;

	res_t slot_results [$];
	int   errors, n_items, n_spawns, n_ticks, n_results, cycles;
	int   send_idle_pct, recv_idle_pct;

	const longint atan_q16 [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
		58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

	function automatic int clamp32(longint v);
		if (v > 64'sd2147483647) return 32'h7FFFFFFF;
		if (v < -64'sd2147483648) return 32'h80000000;
		return int'(v);
	endfunction

	function automatic longint scale_dt(int a, int unsigned dt);
		longint p;
		p = longint'(a) * longint'(dt);
		return (p + 32768) >>> 16;
	endfunction

	task automatic polar_velocity(input logic signed [15:0] ang, input logic [30:0] spd,
			output int ox, output int oy);
		longint z, x, y, nx;
		bit     flip;
		z    = longint'(ang) * 512;
		x    = longint'(spd) * 256;
		y    = 0;
		flip = 0;
		if (z >= 180 * 65536) z -= 360 * 65536;
		if (z < -180 * 65536) z += 360 * 65536;
		if (z > 90 * 65536) begin
			z -= 180 * 65536;
			flip = 1;
		end else if (z < -90 * 65536) begin
			z += 180 * 65536;
			flip = 1;
		end
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y  = y + (x >>> i);
				z -= atan_q16[i];
			end else begin
				nx = x + (y >>> i);
				y  = y - (x >>> i);
				z += atan_q16[i];
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		ox = clamp32((x * 636752 + (64'sd1 <<< 27)) >>> 28);
		oy = clamp32((y * 636752 + (64'sd1 <<< 27)) >>> 28);
	endtask

	function automatic res_t slot_report(int s, bit alv, bit lst);
		res_t r;
		r.valid_res   = 1'b1;
		r.slot_index  = s[5:0];
		r.now_x       = px[s];
		r.now_y       = py[s];
		r.out_radius  = radius[s];
		r.out_color   = color[s];
		r.still_alive = alv;
		r.last        = lst;
		return r;
	endfunction

	task automatic predict_item(input cmd_t c);
		res_t        batch [$];
		res_t        r;
		int          s;
		int unsigned dt;
		if (c.opcode == OP_SPAWN) begin
			s = wr_ptr;
			polar_velocity(c.angle_deg, c.start_speed, vx[s], vy[s]);
			px[s]     = c.start_x;
			py[s]     = c.start_y;
			life[s]   = int'({1'b0, c.life_span});
			radius[s] = c.dot_radius;
			color[s]  = c.rgba_color;
			alive[s]  = 1;
			wr_ptr    = (s + 1 >= POOL) ? 0 : s + 1;
			slot_results.push_back(slot_report(s, 1, 1));
			n_spawns++;
		end else begin
			dt = {8'd0, c.time_step};
			for (int i = 0; i < POOL; i++) begin
				if (!alive[i]) continue;
				px[i]   = clamp32(longint'(px[i]) + scale_dt(vx[i], dt));
				py[i]   = clamp32(longint'(py[i]) + scale_dt(vy[i], dt));
				vy[i]   = clamp32(longint'(vy[i]) + scale_dt(gravity, dt));
				life[i] = clamp32(longint'(life[i]) - longint'(dt));
				if (life[i] <= 0) alive[i] = 0;
				if (batch.size() < MAX_RES) batch.push_back(slot_report(i, alive[i], 0));
			end
			if (batch.size() == 0) begin
				r      = '0;
				r.last = 1'b1;
				batch.push_back(r);
			end else begin
				batch[batch.size() - 1].last = 1'b1;
			end
			foreach (batch[k]) slot_results.push_back(batch[k]);
			n_ticks++;
		end
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("[%0t] mismatch %s: got %0h, want %0h", $realtime, what, got, want);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		res_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{valid_res, slot_index, now_x, now_y, out_radius, out_color,
				still_alive, last};
			n_results++;
			if (slot_results.size() == 0) begin
				report_mismatch("unexpected result, slot", got.slot_index, 0);
			end else begin
				want = slot_results.pop_front();
				if (got.valid_res != want.valid_res)
					report_mismatch("valid_res", got.valid_res, want.valid_res);
				if (got.slot_index != want.slot_index)
					report_mismatch("slot_index", got.slot_index, want.slot_index);
				if (got.now_x != want.now_x)
					report_mismatch("now_x", got.now_x, want.now_x);
				if (got.now_y != want.now_y)
					report_mismatch("now_y", got.now_y, want.now_y);
				if (got.out_radius != want.out_radius)
					report_mismatch("out_radius", got.out_radius, want.out_radius);
				if (got.out_color != want.out_color)
					report_mismatch("out_color", got.out_color, want.out_color);
				if (got.still_alive != want.still_alive)
					report_mismatch("still_alive", got.still_alive, want.still_alive);
				if (got.last != want.last)
					report_mismatch("last", got.last, want.last);
			end
		end
	end

	// result back-pressure
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYC_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, slot_results.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Called at a rising edge; returns at the edge that accepted the item.
	task automatic send_item(input cmd_t c);
		int gap;
		gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 5) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= c.opcode;
		start_x     <= c.start_x;
		start_y     <= c.start_y;
		angle_deg   <= c.angle_deg;
		start_speed <= c.start_speed;
		life_span   <= c.life_span;
		dot_radius  <= c.dot_radius;
		rgba_color  <= c.rgba_color;
		time_step   <= c.time_step;
		do @(posedge clk); while (!in_ready);
		predict_item(c);
		n_items++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (slot_results.size() != 0) @(posedge clk);
		// let the final write-back of a tick settle
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_gravity(input int g);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= g;
		@(posedge clk);
		cfg_we    <= 1'b0;
		gravity    = g;
	endtask

	function automatic cmd_t noise_cmd(logic op);
		cmd_t c;
		c.opcode      = op;
		c.start_x     = $urandom;
		c.start_y     = $urandom;
		c.angle_deg   = 16'($urandom);
		c.start_speed = 31'($urandom);
		c.life_span   = 31'($urandom);
		c.dot_radius  = 31'($urandom);
		c.rgba_color  = $urandom;
		c.time_step   = 24'($urandom);
		return c;
	endfunction

	function automatic cmd_t spawn_cmd(int x, int y, int ang, int spd, int lf);
		cmd_t c;
		c             = noise_cmd(OP_SPAWN);
		c.start_x     = x;
		c.start_y     = y;
		c.angle_deg   = 16'(ang);
		c.start_speed = 31'(spd);
		c.life_span   = 31'(lf);
		return c;
	endfunction

	function automatic cmd_t tick_cmd(int dt);
		cmd_t c;
		c           = noise_cmd(OP_TICK);
		c.time_step = 24'(dt);
		return c;
	endfunction

	task automatic test_empty_pool();
		send_item(tick_cmd(24'h010000));
		send_item(tick_cmd(24'hFFFFFF));
	endtask

	task automatic test_spawn_extremes();
		send_item(spawn_cmd(32'h7FFFFFFF, 32'h80000000, 0, 31'h7FFFFFFF, 31'h7FFFFFFF));
		send_item(spawn_cmd(32'h80000000, 32'h7FFFFFFF, 90 * 128, 31'h7FFFFFFF, 5 << 16));
		send_item(spawn_cmd(0, 0, -90 * 128, 1 << 20, 3 << 16));
		send_item(spawn_cmd(0, 0, 180 * 128, 1 << 16, 2 << 16));
		send_item(spawn_cmd(0, 0, -180 * 128, 1 << 16, 2 << 16));
		send_item(spawn_cmd(100, -100, 32767, 1 << 18, 4 << 16));
		send_item(spawn_cmd(-100, 100, -32768, 1 << 18, 4 << 16));
		send_item(spawn_cmd(1, 1, 45 * 128, 0, 1 << 16));
		send_item(spawn_cmd(5, 5, 30 * 128, 1 << 16, 0));    // zero life, dies next tick
		send_item(spawn_cmd(7, 7, 135 * 128, 1 << 16, 1));
	endtask

	task automatic test_tick_extremes();
		send_item(tick_cmd(0));
		send_item(tick_cmd(24'h000001));
		send_item(tick_cmd(24'h008000));
		send_item(tick_cmd(24'hFFFFFF));
		send_item(tick_cmd(24'h010000));
	endtask

	task automatic test_gravity_extremes();
		write_gravity(32'h80000000);
		send_item(spawn_cmd(0, 32'h80000010, 90 * 128, 1 << 16, 31'h7FFFFFFF));
		send_item(tick_cmd(24'hFFFFFF));
		send_item(tick_cmd(24'hFFFFFF));
		write_gravity(32'h7FFFFFFF);
		send_item(tick_cmd(24'hFFFFFF));
		send_item(tick_cmd(24'hFFFFFF));
		send_item(tick_cmd(24'h000100));
	endtask

	function automatic cmd_t random_cmd();
		cmd_t c;
		if ($urandom_range(99) < 60) begin
			c = noise_cmd(OP_SPAWN);
			if ($urandom_range(7) != 0) begin
				c.start_speed = 31'($urandom_range(0, 1 << 22));
				c.life_span   = 31'($urandom_range(0, 12 << 16));
			end
			if ($urandom_range(7) == 0) c.start_x = $urandom_range(1) ? 32'h7FFFFFF0 : 32'h80000010;
		end else begin
			c = noise_cmd(OP_TICK);
			if ($urandom_range(9) != 0) c.time_step = 24'($urandom_range(0, 24'h00C000));
		end
		return c;
	endfunction

	task automatic test_random_phase(int snd, int rcv, int g, int count);
		write_gravity(g);
		send_idle_pct = snd;
		recv_idle_pct = rcv;
		repeat (count) send_item(random_cmd());
	endtask

	initial begin
		errors = 0;
		n_items = 0;
		n_spawns = 0;
		n_ticks = 0;
		n_results = 0;
		cycles = 0;
		gravity = 0;
		wr_ptr = 0;
		foreach (alive[i]) begin
			px[i] = 0; py[i] = 0; vx[i] = 0; vy[i] = 0; life[i] = 0;
			radius[i] = '0; color[i] = '0; alive[i] = 0;
		end
		send_idle_pct = 29;
		recv_idle_pct = 68;
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_wdata   <= '0;
		in_valid    <= 1'b0;
		opcode      <= OP_SPAWN;
		start_x     <= '0;
		start_y     <= '0;
		angle_deg   <= '0;
		start_speed <= '0;
		life_span   <= '0;
		dot_radius  <= '0;
		rgba_color  <= '0;
		time_step   <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_pool();
		test_spawn_extremes();
		test_tick_extremes();
		test_gravity_extremes();
		test_random_phase(29, 68, $urandom_range(0, 32'h000A0000) - 32'h00050000, 100);
		test_random_phase(68, 29, 32'hFFF60000, 100);
		test_random_phase(0, 0, 0, 100);

		wait_idle();
		$display("covered %0d items (%0d spawns, %0d ticks), %0d results checked",
			n_items, n_spawns, n_ticks, n_results);
		$display("gravity swept through both extremes, zero and random values");
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/ppes_pkg.sv
rtl/ppes_front.sv
rtl/ppes_cordic.sv
rtl/ppes_back.sv
rtl/particle_pool_euler_step_top.sv
dv/tb_particle_pool_euler_step_top.sv
